// ===== src/lbb_pkg.sv =====
// Shared types and constants for the line box blur block.
// Used by the controller, the datapath, the top level and the port checker.
package lbb_pkg;

  localparam int LbbMaxRadius = 31;
  localparam int LbbMaxLine   = 65535;

  localparam int NumChan    = 4;
  localparam int ChanW      = 16;
  localparam int ChanMax    = 65535;
  localparam int RadiusW    = 5;
  localparam int ScaleW     = 17;
  localparam int FracW      = 16;
  localparam int RoundHalf  = 32768;
  localparam int CfgIdxW    = 1;
  localparam int CfgDataW   = ScaleW;

  localparam logic [RadiusW-1:0] RadiusReset = RadiusW'(1);
  localparam logic [ScaleW-1:0]  ScaleReset  = ScaleW'(21845);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RADIUS = 1'b0,
    CFG_SCALE  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [ChanW-1:0] in_red;
    logic [ChanW-1:0] in_green;
    logic [ChanW-1:0] in_blue;
    logic [ChanW-1:0] in_alpha;
    logic             line_end;
  } in_beat_t;

  typedef struct packed {
    logic [ChanW-1:0] out_red;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_blue;
    logic [ChanW-1:0] out_alpha;
    logic             out_line_end;
  } out_beat_t;

  typedef logic [NumChan-1:0][ChanW-1:0] px_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;    // take the input beat, write the ring, issue the slide-out read
    logic upd;       // update the running sums
    logic flush;     // slide-out index follows the right-edge flush rule
    logic frd;       // issue a flush ring read
    logic step_inc;  // advance the flush step
    logic mul;       // multiply sums by scale
    logic emit;      // load the output register
    logic finish;    // advance or restart the line position
  } lbb_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic last;       // current pixel closes the line
    logic emit_ok;    // a result is due at this step
    logic step_done;  // flush step reached the line radius
    logic out_free;   // output register can take a beat
  } lbb_status_t;

endpackage

// ===== src/lbb_ctrl.sv =====
// Controller for the line box blur: sequences one pixel and its flush steps.
// Depends on lbb_pkg for the command and status structs.
module lbb_ctrl import lbb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  lbb_status_t sts_i,
  output lbb_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_DECIDE,
    S_MUL,
    S_EMIT,
    S_FRD,
    S_FUPD
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_UPD;
        end
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts_i.emit_ok) begin
          state_d = S_MUL;
        end else if (!sts_i.last) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end else begin
          // left edge of a short flush: skip the result, keep sliding
          state_d = S_FRD;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (!sts_i.last || sts_i.step_done) begin
            cmd_o.finish = 1'b1;
            state_d      = S_IDLE;
          end else begin
            state_d = S_FRD;
          end
        end
      end
      S_FRD: begin
        cmd_o.frd = 1'b1;
        state_d   = S_FUPD;
      end
      S_FUPD: begin
        cmd_o.upd      = 1'b1;
        cmd_o.flush    = 1'b1;
        cmd_o.step_inc = 1'b1;
        state_d        = S_DECIDE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

// ===== src/lbb_datapath.sv =====
// Datapath for the line box blur: config registers, window ring memory,
// running sums, scale multipliers and the output register. Uses lbb_pkg.
module lbb_datapath import lbb_pkg::*; #(
  parameter int MaxRadius = LbbMaxRadius,
  parameter int MaxLine   = LbbMaxLine
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  in_beat_t            in_data_i,
  input  lbb_cmd_t            cmd_i,
  output lbb_status_t         sts_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output out_beat_t           out_data_o
);

  localparam int Depth = 2 * MaxRadius + 2;
  localparam int PtrW  = $clog2(Depth);
  localparam int RW    = $clog2(MaxRadius + 1);
  localparam int PosW  = $clog2(MaxLine);
  localparam int SumW  = $clog2((2 * MaxRadius + 1) * ChanMax + 1);
  localparam int ProdW = SumW + ScaleW;
  localparam int ShW   = ProdW + 1 - FracW;
  localparam int AddrW = PtrW + 2;
  localparam int CmpW  = ((PosW > RW) ? PosW : RW) + 2;

  // configuration
  logic [RadiusW-1:0] radius_q;
  logic [ScaleW-1:0]  scale_q;

  // line control
  logic [PosW-1:0] pos_q;
  logic [PtrW-1:0] wr_ptr_q;
  logic [RW-1:0]   line_r_q;
  logic [RW-1:0]   step_q;
  logic            last_q;

  // payload
  px_t                   ring_mem [Depth];
  px_t                   rd_q;
  px_t                   px_q;
  px_t                   first_q;
  px_t                   px_in;
  px_t                   old_px;
  logic [SumW-1:0]       sums_q   [NumChan];
  logic [SumW-1:0]       sums_nxt [NumChan];
  logic [ProdW-1:0]      prod_q   [NumChan];
  logic [ChanW-1:0]      chan_out [NumChan];
  logic [RW+ChanW:0]     init_prod[NumChan];
  logic [SumW:0]         slide    [NumChan];
  logic [ProdW:0]        rnd      [NumChan];
  logic [ShW-1:0]        shifted  [NumChan];
  out_beat_t             out_q;
  logic                  out_valid_q;

  logic            line_start;
  logic [RW-1:0]   r_cfg;
  logic [RW-1:0]   rd_off;
  logic [AddrW-1:0] rd_sum;
  logic [PtrW-1:0] rd_addr;
  logic            rd_en;
  logic [CmpW-1:0] pw;
  logic [CmpW-1:0] two_r;
  logic            use_ring;
  logic            in_last;

  assign px_in[0] = in_data_i.in_red;
  assign px_in[1] = in_data_i.in_green;
  assign px_in[2] = in_data_i.in_blue;
  assign px_in[3] = in_data_i.in_alpha;

  assign line_start = (pos_q == '0);
  assign r_cfg      = (int'(radius_q) > MaxRadius) ? RW'(MaxRadius) : RW'(radius_q);
  assign in_last    = in_data_i.line_end || (pos_q >= PosW'(MaxLine - 1));

  // Slide-out address: pos - 2r - 1 on accept, pos + step - 2r while flushing
  assign rd_off  = cmd_i.accept ? '0 : step_q;
  assign rd_sum  = AddrW'(wr_ptr_q) + AddrW'(rd_off) + AddrW'(Depth)
                 - AddrW'({line_r_q, 1'b0}) - AddrW'(cmd_i.accept);
  assign rd_addr = (rd_sum >= AddrW'(Depth)) ? PtrW'(rd_sum - AddrW'(Depth))
                                              : PtrW'(rd_sum);
  assign rd_en   = cmd_i.accept || cmd_i.frd;

  assign pw       = CmpW'(pos_q) + CmpW'(step_q);
  assign two_r    = CmpW'({line_r_q, 1'b0});
  assign use_ring = cmd_i.flush ? (pw >= two_r) : (pw >= two_r + CmpW'(1));
  assign old_px   = use_ring ? rd_q : first_q;

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      init_prod[c] = {line_r_q, 1'b1} * px_q[c];
      slide[c]     = (SumW+1)'(sums_q[c]) + (SumW+1)'(px_q[c]) - (SumW+1)'(old_px[c]);
      if (line_start) begin
        sums_nxt[c] = SumW'(init_prod[c]);
      end else begin
        sums_nxt[c] = slide[c][SumW-1:0];
      end
      // round half up, then saturate
      rnd[c]     = (ProdW+1)'(prod_q[c]) + (ProdW+1)'(RoundHalf);
      shifted[c] = rnd[c][ProdW:FracW];
      if (shifted[c] > ShW'(ChanMax)) begin
        chan_out[c] = ChanW'(ChanMax);
      end else begin
        chan_out[c] = shifted[c][ChanW-1:0];
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q    <= RadiusReset;
      scale_q     <= ScaleReset;
      pos_q       <= '0;
      wr_ptr_q    <= '0;
      line_r_q    <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_RADIUS: radius_q <= cfg_data_i[RadiusW-1:0];
          CFG_SCALE:  scale_q  <= cfg_data_i[ScaleW-1:0];
          default:    ;
        endcase
      end
      if (cmd_i.accept) begin
        step_q <= '0;
        if (line_start) begin
          line_r_q <= r_cfg;
        end
      end else if (cmd_i.step_inc) begin
        step_q <= step_q + RW'(1);
      end
      if (cmd_i.finish) begin
        if (last_q) begin
          pos_q    <= '0;
          wr_ptr_q <= '0;
        end else begin
          pos_q    <= pos_q + PosW'(1);
          wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      px_q   <= px_in;
      last_q <= in_last;
      if (line_start) begin
        first_q <= px_in;
      end
    end
    for (int c = 0; c < NumChan; c++) begin
      if (cmd_i.upd) begin
        sums_q[c] <= sums_nxt[c];
      end
      if (cmd_i.mul) begin
        prod_q[c] <= sums_q[c] * scale_q;
      end
    end
    if (cmd_i.emit) begin
      out_q.out_red      <= chan_out[0];
      out_q.out_green    <= chan_out[1];
      out_q.out_blue     <= chan_out[2];
      out_q.out_alpha    <= chan_out[3];
      out_q.out_line_end <= last_q && (step_q == line_r_q);
    end
  end

  // window ring: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ring_mem[wr_ptr_q] <= px_in;
    end
    if (rd_en) begin
      rd_q <= ring_mem[rd_addr];
    end
  end

  assign sts_o.last      = last_q;
  assign sts_o.emit_ok   = (pw >= CmpW'(line_r_q));
  assign sts_o.step_done = (step_q == line_r_q);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== src/line_box_blur_running_sum.sv =====
// Line box blur with edge replication over four 16-bit channels.
// A result passes through the sum update, decide, scale multiply and output load states after
// its pixel is accepted. The controller walks one pixel at a time through ring read, sum update,
// scale multiply and output load, and takes no new pixel until it is done; output stall holds it.
// The line-end pixel then runs flush steps (ring read, sum update) up to the line radius.
// Reset clears position, config (radius 1, scale 21845) and the output valid; ring is unreset.
module line_box_blur_running_sum import lbb_pkg::*; #(
  parameter int MaxRadius = LbbMaxRadius,
  parameter int MaxLine   = LbbMaxLine
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_beat_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_beat_t           out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  lbb_cmd_t    cmd;
  lbb_status_t sts;

  assign cfg_ready_o = 1'b1;

  lbb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lbb_datapath #(
    .MaxRadius (MaxRadius),
    .MaxLine   (MaxLine)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== src/lbb_checker.sv =====
// Port-level checks for the line box blur top level, attached by bind.
// Depends on lbb_pkg for the beat types.
module lbb_checker import lbb_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_beat_t out_data_o
);

  // one pixel in work at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after a beat");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat dropped or changed");

  // a fresh result appears only while a pixel is in work
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result beat without a pixel in work");

endmodule

bind line_box_blur_running_sum lbb_checker u_lbb_checker (.*);

// ===== test/tb_line_box_blur_running_sum.sv =====
// Testbench for line_box_blur_running_sum: directed and random pixel lines under stall.
// Keeps its own edge-replicating running-sum model of the blur to predict each result.
// Depends on lbb_pkg for the beat structs, the register codes and the widths.
module tb_line_box_blur_running_sum;
  import lbb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RingDepth   = 2 * LbbMaxRadius + 2;
  localparam int DrainCycles = 16;
  localparam int CycleLimit  = 4_000_000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  in_beat_t            in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_beat_t           out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = CFG_RADIUS;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  line_box_blur_running_sum dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Blur model state
  px_t               win_ring [RingDepth];
  logic [31:0]       run_sum [NumChan];
  px_t               line_first;
  int unsigned       line_pos;
  int unsigned       line_rad;
  logic [RadiusW-1:0] cfg_radius;
  logic [ScaleW-1:0]  cfg_scale;

  out_beat_t   expected_blur_q [$];
  out_beat_t   blur_exp;
  int unsigned blur_errors = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned cycle_count = 0;

  function automatic logic [ChanW-1:0] scale_chan(logic [31:0] sum);
    logic [63:0] v;
    v = (64'(sum) * 64'(cfg_scale) + 64'(RoundHalf)) >> FracW;
    return (v > 64'(ChanMax)) ? ChanW'(ChanMax) : v[ChanW-1:0];
  endfunction

  function automatic void push_blur_result(bit last);
    out_beat_t e;
    e.out_red      = scale_chan(run_sum[0]);
    e.out_green    = scale_chan(run_sum[1]);
    e.out_blue     = scale_chan(run_sum[2]);
    e.out_alpha    = scale_chan(run_sum[3]);
    e.out_line_end = last;
    expected_blur_q.push_back(e);
  endfunction

  function automatic void slide_sums(px_t add, px_t drop);
    for (int c = 0; c < NumChan; c++) begin
      run_sum[c] = run_sum[c] + 32'(add[c]) - 32'(drop[c]);
    end
  endfunction

  function automatic void blur_predict_pixel(in_beat_t beat);
    px_t         px;
    px_t         old;
    int unsigned p;
    int unsigned r;
    bit          last;
    px[0] = beat.in_red;
    px[1] = beat.in_green;
    px[2] = beat.in_blue;
    px[3] = beat.in_alpha;
    p = line_pos;
    last = beat.line_end || (p >= LbbMaxLine - 1);
    if (p == 0) begin
      line_rad = (cfg_radius > LbbMaxRadius) ? LbbMaxRadius : cfg_radius;
      r = line_rad;
      line_first = px;
      for (int c = 0; c < NumChan; c++) begin
        run_sum[c] = 32'(2 * r + 1) * 32'(px[c]);
      end
    end else begin
      r = line_rad;
      old = (p >= 2 * r + 1) ? win_ring[(p - 2 * r - 1) % RingDepth] : line_first;
      slide_sums(px, old);
    end
    win_ring[p % RingDepth] = px;
    if (!last) begin
      if (p >= r) push_blur_result(1'b0);
      line_pos = p + 1;
      return;
    end
    // Flush the right edge: replicate the last pixel for the remaining positions
    for (int unsigned step = 0; step <= r; step++) begin
      if (p + step >= r) push_blur_result(step == r);
      if (step < r) begin
        old = (p + step >= 2 * r) ? win_ring[(p + step - 2 * r) % RingDepth] : line_first;
        slide_sums(px, old);
      end
    end
    line_pos = 0;
  endfunction

  function automatic void report_blur_error(string what, out_beat_t e, out_beat_t a);
    blur_errors++;
    if (blur_errors <= 10) begin
      $display("%0s at cycle %0d: expected r=%h g=%h b=%h a=%h end=%b,",
               what, cycle_count, e.out_red, e.out_green, e.out_blue, e.out_alpha,
               e.out_line_end);
      $display("  got r=%h g=%h b=%h a=%h end=%b",
               a.out_red, a.out_green, a.out_blue, a.out_alpha, a.out_line_end);
    end
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_blur_q.size() == 0) begin
        report_blur_error("unexpected result", '0, out_data_o);
      end else begin
        blur_exp = expected_blur_q.pop_front();
        if (out_data_o.out_red !== blur_exp.out_red ||
            out_data_o.out_green !== blur_exp.out_green ||
            out_data_o.out_blue !== blur_exp.out_blue ||
            out_data_o.out_alpha !== blur_exp.out_alpha ||
            out_data_o.out_line_end !== blur_exp.out_line_end) begin
          report_blur_error("mismatch", blur_exp, out_data_o);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("FAILURE");
    $finish;
  end

  function automatic logic [ChanW-1:0] rand_chan();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return ChanW'($urandom);
    endcase
  endfunction

  function automatic in_beat_t mk_pixel(logic [ChanW-1:0] r, logic [ChanW-1:0] g,
                                        logic [ChanW-1:0] b, logic [ChanW-1:0] a,
                                        logic le);
    in_beat_t beat;
    beat.in_red   = r;
    beat.in_green = g;
    beat.in_blue  = b;
    beat.in_alpha = a;
    beat.line_end = le;
    return beat;
  endfunction

  function automatic in_beat_t rand_pixel(logic le);
    return mk_pixel(rand_chan(), rand_chan(), rand_chan(), rand_chan(), le);
  endfunction

  function automatic logic [CfgDataW-1:0] pick_radius();
    case ($urandom_range(0, 7))
      0:       return CfgDataW'(0);
      1:       return CfgDataW'(LbbMaxRadius);
      2:       return CfgDataW'($urandom_range(0, 31));
      default: return CfgDataW'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic logic [CfgDataW-1:0] pick_scale(int unsigned r);
    case ($urandom_range(0, 5))
      0: return CfgDataW'($urandom_range(0, 131071));
      1: begin
        case ($urandom_range(0, 2))
          0:       return CfgDataW'(0);
          1:       return CfgDataW'(65536);
          default: return CfgDataW'(131071);
        endcase
      end
      // rounded reciprocal of the window size
      default: return CfgDataW'((131072 + 2 * r + 1) / (2 * (2 * r + 1)));
    endcase
  endfunction

  function automatic int unsigned pick_line_len();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(65, 140);
      1, 2:    return 1;
      default: return $urandom_range(2, 12);
    endcase
  endfunction

  task automatic send_pixel(in_beat_t beat);
    bit taken;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = beat;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !in_stall_o;
    end
    blur_predict_pixel(beat);
  endtask

  task automatic write_blur_reg(cfg_reg_e idx, logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_RADIUS) cfg_radius = value[RadiusW-1:0];
    else cfg_scale = value[ScaleW-1:0];
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Drop valid, wait out all expected results, then let the pipeline settle
  task automatic drain_blur_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_blur_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic test_reset_config();
    send_pixel(mk_pixel('1, '1, '1, '1, 1'b0));
    send_pixel(mk_pixel('0, '0, '0, '0, 1'b0));
    send_pixel(mk_pixel('1, '0, 16'h8000, 16'h0001, 1'b1));
    send_pixel(mk_pixel('1, '1, '1, '1, 1'b1));
  endtask

  task automatic test_radius_zero();
    drain_blur_results();
    write_blur_reg(CFG_RADIUS, CfgDataW'(0));
    write_blur_reg(CFG_SCALE, CfgDataW'(65536));
    send_pixel(mk_pixel('1, '0, 16'h1234, 16'h8000, 1'b0));
    send_pixel(mk_pixel('0, '1, 16'hedcb, 16'h7fff, 1'b1));
  endtask

  task automatic test_wide_window_short_line();
    drain_blur_results();
    write_blur_reg(CFG_RADIUS, CfgDataW'(LbbMaxRadius));
    write_blur_reg(CFG_SCALE, CfgDataW'(131071));
    send_pixel(mk_pixel('1, '1, '1, '1, 1'b0));
    send_pixel(mk_pixel('1, '0, '1, '0, 1'b0));
    send_pixel(mk_pixel('1, '1, '1, '1, 1'b1));
    drain_blur_results();
    write_blur_reg(CFG_SCALE, CfgDataW'(0));
    send_pixel(mk_pixel('1, '1, '1, '1, 1'b1));
  endtask

  task automatic test_radius_change_mid_line();
    drain_blur_results();
    write_blur_reg(CFG_RADIUS, CfgDataW'(2));
    write_blur_reg(CFG_SCALE, CfgDataW'(13107));
    send_pixel(mk_pixel(16'h1000, 16'h2000, 16'h3000, 16'h4000, 1'b0));
    send_pixel(mk_pixel(16'hf000, 16'he000, 16'hd000, 16'hc000, 1'b0));
    // the new radius must wait for the next line
    drain_blur_results();
    write_blur_reg(CFG_RADIUS, CfgDataW'(0));
    send_pixel(mk_pixel(16'h0f0f, 16'hf0f0, 16'h5555, 16'haaaa, 1'b0));
    send_pixel(mk_pixel('1, '0, '1, '0, 1'b0));
    send_pixel(mk_pixel('0, '1, '0, '1, 1'b1));
    send_pixel(mk_pixel(16'h4321, 16'h8765, 16'hcba9, 16'h0fed, 1'b0));
    send_pixel(mk_pixel(16'h0001, 16'hfffe, 16'h8001, 16'h7ffe, 1'b1));
  endtask

  task automatic test_random_lines(int unsigned n_items, int unsigned snd_pct,
                                   int unsigned rcv_pct);
    int unsigned         sent;
    int unsigned         len;
    logic [CfgDataW-1:0] rad;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 2) == 0) begin
        drain_blur_results();
        rad = pick_radius();
        write_blur_reg(CFG_RADIUS, rad);
        write_blur_reg(CFG_SCALE, pick_scale(rad));
      end
      len = pick_line_len();
      for (int unsigned k = 0; k < len; k++) begin
        if (k > 0 && k == len / 2 && $urandom_range(0, 9) == 0) begin
          drain_blur_results();
          write_blur_reg(CFG_RADIUS, pick_radius());
        end
        send_pixel(rand_pixel(k == len - 1));
        sent++;
      end
    end
  endtask

  initial begin
    cfg_radius = RadiusReset;
    cfg_scale  = ScaleReset;
    line_pos   = 0;
    line_rad   = 0;
    line_first = '0;
    for (int c = 0; c < NumChan; c++) run_sum[c] = '0;
    send_idle_pct = 6;
    recv_idle_pct = 49;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_config();
    test_radius_zero();
    test_wide_window_short_line();
    test_radius_change_mid_line();
    test_random_lines(130, 6, 49);
    test_random_lines(130, 49, 6);
    test_random_lines(130, 0, 0);

    drain_blur_results();
    if (expected_blur_q.size() != 0) begin
      report_blur_error("left over", expected_blur_q[0], '0);
    end
    if (blur_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
